FILE: src/catmull_rom_point_eval_macros.svh
// Assertion macros shared by the point evaluator RTL.
`ifndef CATMULL_ROM_POINT_EVAL_MACROS_SVH
`define CATMULL_ROM_POINT_EVAL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CRPE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crpe assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CRPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crpe assertion failed");

`endif

FILE: src/crpe_pkg.sv
// Types, widths and constants of the Catmull-Rom point evaluator.
package crpe_pkg;

    // Number formats
    localparam int COORD_WIDTH = 32;
    localparam int T_FRAC_BITS = 16;
    localparam int T_W         = T_FRAC_BITS + 1;
    // Hermite weights lie in [-1, 1] in Q.F; two guard bits on top
    localparam int WGT_W       = T_FRAC_BITS + 4;
    localparam int WGT2_W      = WGT_W + 1;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = WGT2_W + DIFF_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int ACC_W       = PROD_W + 2;

    // Pipeline stage indexes
    localparam int ST_T2      = 0;
    localparam int ST_T3      = 1;
    localparam int ST_WGT     = 2;
    localparam int ST_MUL     = 3;
    localparam int ST_PAIR    = 4;
    localparam int ST_ACC     = 5;
    localparam int ST_OUT     = 6;
    localparam int NUM_STAGES = 7;

    localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [T_W-1:0] T_RND = {2'b01, {(T_FRAC_BITS - 1){1'b0}}};

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    // Rounding term: half of the final 2^(F+1) scale
    localparam logic signed [ACC_W-1:0] ACC_HALF =
        {{(ACC_W - T_FRAC_BITS - 1){1'b0}}, 1'b1, {T_FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic        [T_W-1:0]         t_param;
        logic signed [COORD_WIDTH-1:0] p0_x;
        logic signed [COORD_WIDTH-1:0] p0_y;
        logic signed [COORD_WIDTH-1:0] p1_x;
        logic signed [COORD_WIDTH-1:0] p1_y;
        logic signed [COORD_WIDTH-1:0] p2_x;
        logic signed [COORD_WIDTH-1:0] p2_y;
        logic signed [COORD_WIDTH-1:0] p3_x;
        logic signed [COORD_WIDTH-1:0] p3_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic                          clipped;
    } out_item_t;

    typedef struct packed {
        logic signed [WGT_W-1:0] w00;
        logic signed [WGT_W-1:0] w01;
        logic signed [WGT_W-1:0] w10;
        logic signed [WGT_W-1:0] w11;
    } weights_t;

    // Per-stage load enables
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } pipe_ctrl_t;

endpackage

FILE: src/crpe_weights.sv
// Hermite basis weights from the curve parameter, three register stages.
module crpe_weights (
    input  logic                          clk,
    input  crpe_pkg::pipe_ctrl_t          ctrl,
    input  logic [crpe_pkg::T_W-1:0]      t_param,
    output crpe_pkg::weights_t            weights
);

    localparam int TW  = crpe_pkg::T_W;
    localparam int WW  = crpe_pkg::WGT_W;
    localparam int SQW = 2 * TW;

    logic [TW-1:0]  t_clamp;
    logic [SQW-1:0] t_sq;
    logic [SQW-1:0] t_cube;
    logic [TW-1:0]  t2_next;
    logic [TW-1:0]  t3_next;

    logic [TW-1:0]  t_a_reg;
    logic [TW-1:0]  t2_a_reg;
    logic [TW-1:0]  t_b_reg;
    logic [TW-1:0]  t2_b_reg;
    logic [TW-1:0]  t3_b_reg;

    logic signed [WW-1:0] ts;
    logic signed [WW-1:0] q2s;
    logic signed [WW-1:0] q3s;
    logic signed [WW-1:0] one_s;
    crpe_pkg::weights_t   weights_next;
    crpe_pkg::weights_t   weights_reg;

    // Stage A: clamp t to 1.0 and square it, round to nearest
    always_comb
    begin
        t_clamp = (t_param > crpe_pkg::T_ONE) ? crpe_pkg::T_ONE : t_param;
        t_sq    = SQW'(t_clamp) * SQW'(t_clamp);
        t2_next = TW'((t_sq + SQW'(crpe_pkg::T_RND)) >> crpe_pkg::T_FRAC_BITS);
    end

    // Stage B: cube from the rounded square
    always_comb
    begin
        t_cube  = SQW'(t2_a_reg) * SQW'(t_a_reg);
        t3_next = TW'((t_cube + SQW'(crpe_pkg::T_RND)) >> crpe_pkg::T_FRAC_BITS);
    end

    // Stage C: the four weights, all exact in Q.F
    always_comb
    begin
        ts    = $signed({{(WW - TW){1'b0}}, t_b_reg});
        q2s   = $signed({{(WW - TW){1'b0}}, t2_b_reg});
        q3s   = $signed({{(WW - TW){1'b0}}, t3_b_reg});
        one_s = $signed({{(WW - TW){1'b0}}, crpe_pkg::T_ONE});
        weights_next.w00 = (q3s <<< 1) - (q2s + (q2s <<< 1)) + one_s;
        weights_next.w01 = (q2s + (q2s <<< 1)) - (q3s <<< 1);
        weights_next.w10 = q3s - (q2s <<< 1) + ts;
        weights_next.w11 = q3s - q2s;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[crpe_pkg::ST_T2])
        begin
            t_a_reg  <= t_clamp;
            t2_a_reg <= t2_next;
        end
        if (ctrl.en[crpe_pkg::ST_T3])
        begin
            t_b_reg  <= t_a_reg;
            t2_b_reg <= t2_a_reg;
            t3_b_reg <= t3_next;
        end
        if (ctrl.en[crpe_pkg::ST_WGT])
        begin
            weights_reg <= weights_next;
        end
    end

    assign weights = weights_reg;

endmodule

FILE: src/crpe_axis.sv
// Weighted sum, rounding and saturation for one coordinate axis.
module crpe_axis (
    input  logic                                  clk,
    input  crpe_pkg::pipe_ctrl_t                  ctrl,
    input  logic signed [crpe_pkg::COORD_WIDTH-1:0] c0,
    input  logic signed [crpe_pkg::COORD_WIDTH-1:0] c1,
    input  logic signed [crpe_pkg::COORD_WIDTH-1:0] c2,
    input  logic signed [crpe_pkg::COORD_WIDTH-1:0] c3,
    input  crpe_pkg::weights_t                    weights,
    output logic signed [crpe_pkg::COORD_WIDTH-1:0] coord,
    output logic                                  sat
);

    localparam int CW    = crpe_pkg::COORD_WIDTH;
    localparam int DW    = crpe_pkg::DIFF_W;
    localparam int W2    = crpe_pkg::WGT2_W;
    localparam int PW    = crpe_pkg::PROD_W;
    localparam int SW    = crpe_pkg::SUM_W;
    localparam int AW    = crpe_pkg::ACC_W;
    localparam int F     = crpe_pkg::T_FRAC_BITS;

    // Points and tangent differences, carried until the weights are ready
    logic signed [CW-1:0] c1_a_reg, c1_b_reg, c1_c_reg;
    logic signed [CW-1:0] c2_a_reg, c2_b_reg, c2_c_reg;
    logic signed [DW-1:0] d0_a_reg, d0_b_reg, d0_c_reg;
    logic signed [DW-1:0] d1_a_reg, d1_b_reg, d1_c_reg;
    logic signed [DW-1:0] d0_next, d1_next;

    logic signed [W2-1:0] w00x2, w01x2;
    logic signed [PW-1:0] m00_next, m10_next, m01_next, m11_next;
    logic signed [PW-1:0] m00_reg, m10_reg, m01_reg, m11_reg;
    logic signed [SW-1:0] sa_next, sb_next, sa_reg, sb_reg;
    logic signed [AW-1:0] acc_next, acc_reg;

    logic [AW-1-F-CW:0]   acc_hi;
    logic                 fits;
    logic signed [CW-1:0] coord_next, coord_reg;
    logic                 sat_reg;

    // Tangent differences P2-P0 and P3-P1
    always_comb
    begin
        d0_next = DW'(c2) - DW'(c0);
        d1_next = DW'(c3) - DW'(c1);
    end

    // Four products: 2*h00*P1, h10*(P2-P0), 2*h01*P2, h11*(P3-P1)
    always_comb
    begin
        w00x2    = $signed({weights.w00, 1'b0});
        w01x2    = $signed({weights.w01, 1'b0});
        m00_next = w00x2 * c1_c_reg;
        m10_next = weights.w10 * d0_c_reg;
        m01_next = w01x2 * c2_c_reg;
        m11_next = weights.w11 * d1_c_reg;
    end

    // Pair sums, then full sum with rounding term
    always_comb
    begin
        sa_next  = SW'(m00_reg) + SW'(m10_reg);
        sb_next  = SW'(m01_reg) + SW'(m11_reg);
        acc_next = AW'(sa_reg) + AW'(sb_reg) + crpe_pkg::ACC_HALF;
    end

    // Divide by 2^(F+1) and clamp to the coordinate range
    always_comb
    begin
        acc_hi     = acc_reg[AW-1:F+CW];
        fits       = (&acc_hi) || !(|acc_hi);
        coord_next = fits ? acc_reg[F+CW:F+1]
                   : (acc_reg[AW-1] ? crpe_pkg::COORD_MIN : crpe_pkg::COORD_MAX);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[crpe_pkg::ST_T2])
        begin
            c1_a_reg <= c1;
            c2_a_reg <= c2;
            d0_a_reg <= d0_next;
            d1_a_reg <= d1_next;
        end
        if (ctrl.en[crpe_pkg::ST_T3])
        begin
            c1_b_reg <= c1_a_reg;
            c2_b_reg <= c2_a_reg;
            d0_b_reg <= d0_a_reg;
            d1_b_reg <= d1_a_reg;
        end
        if (ctrl.en[crpe_pkg::ST_WGT])
        begin
            c1_c_reg <= c1_b_reg;
            c2_c_reg <= c2_b_reg;
            d0_c_reg <= d0_b_reg;
            d1_c_reg <= d1_b_reg;
        end
        if (ctrl.en[crpe_pkg::ST_MUL])
        begin
            m00_reg <= m00_next;
            m10_reg <= m10_next;
            m01_reg <= m01_next;
            m11_reg <= m11_next;
        end
        if (ctrl.en[crpe_pkg::ST_PAIR])
        begin
            sa_reg <= sa_next;
            sb_reg <= sb_next;
        end
        if (ctrl.en[crpe_pkg::ST_ACC])
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.en[crpe_pkg::ST_OUT])
        begin
            coord_reg <= coord_next;
            sat_reg   <= !fits;
        end
    end

    assign coord = coord_reg;
    assign sat   = sat_reg;

endmodule

FILE: src/catmull_rom_point_eval.sv
// Top level of the uniform 2D Catmull-Rom point evaluator.
// An accepted item passes seven register stages before out_valid rises.
// Throughput: one item per cycle while out_ready is high.
// A stall at the output holds the full stages behind it; a stage moves when the next is free.
// Reset (rst_n, async, active low) clears the stage valid bits only.
`include "catmull_rom_point_eval_macros.svh"

module catmull_rom_point_eval (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  crpe_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output crpe_pkg::out_item_t out_item
);

    localparam int NS = crpe_pkg::NUM_STAGES;

    logic [NS-1:0]        valid_reg;
    logic [NS-1:0]        valid_next;
    logic [NS-1:0]        stage_ready;
    crpe_pkg::pipe_ctrl_t ctrl;
    crpe_pkg::weights_t   weights;
    logic signed [crpe_pkg::COORD_WIDTH-1:0] coord_x;
    logic signed [crpe_pkg::COORD_WIDTH-1:0] coord_y;
    logic                 sat_x;
    logic                 sat_y;
    logic                 in_fire;
    logic                 out_fire;
    logic                 x_at_bound;
    logic                 y_at_bound;

    // Ready ripples back: a stage loads when empty or when its successor loads
    always_comb
    begin
        stage_ready[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        ctrl.en = stage_ready;
    end

    // Valid bits follow their items
    always_comb
    begin
        valid_next[0] = stage_ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = stage_ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    crpe_weights u_weights (
        .clk     (clk),
        .ctrl    (ctrl),
        .t_param (in_item.t_param),
        .weights (weights)
    );

    crpe_axis u_axis_x (
        .clk     (clk),
        .ctrl    (ctrl),
        .c0      (in_item.p0_x),
        .c1      (in_item.p1_x),
        .c2      (in_item.p2_x),
        .c3      (in_item.p3_x),
        .weights (weights),
        .coord   (coord_x),
        .sat     (sat_x)
    );

    crpe_axis u_axis_y (
        .clk     (clk),
        .ctrl    (ctrl),
        .c0      (in_item.p0_y),
        .c1      (in_item.p1_y),
        .c2      (in_item.p2_y),
        .c3      (in_item.p3_y),
        .weights (weights),
        .coord   (coord_y),
        .sat     (sat_y)
    );

    assign out_item  = '{out_x: coord_x, out_y: coord_y, clipped: sat_x || sat_y};
    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NS-1];

    // Handshake and bound flags for the checks
    assign in_fire    = in_valid && in_ready;
    assign out_fire   = out_valid && out_ready;
    assign x_at_bound = (coord_x == crpe_pkg::COORD_MAX) || (coord_x == crpe_pkg::COORD_MIN);
    assign y_at_bound = (coord_y == crpe_pkg::COORD_MAX) || (coord_y == crpe_pkg::COORD_MIN);

    // No input stall while the sink takes items
    `CRPE_ASSERT_IMP(a_no_stall_when_drained, out_ready, in_ready)

    // An item taken in with nothing leaving adds one to the pipeline fill
    `CRPE_ASSERT_NEXT(a_fill_grows, in_fire && !out_fire, $countones(valid_reg) == $past($countones(valid_reg)) + 1)

    // A clipped result carries a saturated coordinate
    `CRPE_ASSERT_IMP(a_clip_at_bound, out_valid && out_item.clipped, x_at_bound || y_at_bound)

endmodule
